// ===== hw/rtl/pidc_pkg.sv =====
// Package for the PID control step core: types, constants and state codes.
// No dependencies. Used by every module under hw/rtl.
package pidc_pkg;

   localparam int VALUE_WIDTH_DEF   = 32;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int COUNT_WRAP_DEF    = 10000;
   localparam int COUNT_BITS        = 14;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_DATA_BITS     = 32;

   // Register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_KP   = 3'd0,
      REG_TI   = 3'd1,
      REG_TD   = 3'd2,
      REG_LAG  = 3'd3,
      REG_HL   = 3'd4,
      REG_LL   = 3'd5,
      REG_DT   = 3'd6,
      REG_MODE = 3'd7
   } reg_index_type;

   // Shared unit operations.
   typedef enum logic [1:0] {
      OP_MUL = 2'd0,
      OP_DIV = 2'd1
   } alu_op_type;

   typedef struct packed {
      logic        enable;
      logic        external_sp_on;
      logic [31:0] external_setpoint;
      logic [31:0] internal_setpoint;
      logic [31:0] process_value;
      logic        manual_on;
      logic [31:0] manual_value;
   } req_payload_type;

   typedef struct packed {
      logic [31:0]           drive_value;
      logic [31:0]           setpoint_used;
      logic [31:0]           control_error;
      logic                  internal_sp_active;
      logic                  status_ok;
      logic [31:0]           tracked_manual_value;
      logic [COUNT_BITS-1:0] cycle_count;
   } rsp_payload_type;

   // Sequencer steps.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_P,
      ST_D1,
      ST_D2,
      ST_D3,
      ST_I1,
      ST_I2,
      ST_I3,
      ST_I4,
      ST_A1,
      ST_A2,
      ST_F1,
      ST_F2,
      ST_FIN,
      ST_OUT
   } seq_state_type;

   // Handshake between sequencer and shared unit.
   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctrl_type;

endpackage

// ===== hw/rtl/pidc_alu.sv =====
// Shared multiply / divide unit for the PID core, one bit per cycle.
// Depends on pidc_pkg. Rounds to nearest, ties away from zero, saturates.
module pidc_alu
   import pidc_pkg::*;
#(
   parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  alu_ctrl_type                  ctrl,
   input  logic signed [VALUE_WIDTH-1:0] opa,
   input  logic signed [VALUE_WIDTH-1:0] opb,
   output logic                          done,
   output logic signed [VALUE_WIDTH-1:0] result
);

   localparam int W  = VALUE_WIDTH;
   localparam int PW = 2 * W + 2;
   localparam int CW = $clog2(PW + 1);
   localparam logic [PW-1:0] VMAX_MAG = PW'({1'b0, {(W-1){1'b1}}});
   localparam logic [PW-1:0] VMIN_MAG = PW'({1'b1, {(W-1){1'b0}}});

   logic          busy_ff, busy_in;
   logic          div_ff, div_in;
   logic          neg_ff, neg_in;
   logic          zero_div_ff, zero_div_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] acc_ff, acc_in;   // product or quotient
   logic [PW-1:0] num_ff, num_in;   // multiplier bits or dividend bits
   logic [PW-1:0] rem_ff, rem_in;
   logic [PW-1:0] mb_ff, mb_in;     // magnitude of b
   logic          done_ff, done_in;
   logic signed [W-1:0] res_ff, res_in;
   logic          sa_ff, sa_in;     // sign of a, for divide by zero
   logic          za_ff, za_in;     // a is zero, for divide by zero

   logic [W:0]    mag_a, mag_b;
   logic [PW-1:0] rem_sh, rnd_q, fin_mag;
   logic [PW:0]   rem_sub;

   assign mag_a = opa[W-1] ? (W+1)'(-{opa[W-1], opa}) : (W+1)'({1'b0, opa});
   assign mag_b = opb[W-1] ? (W+1)'(-{opb[W-1], opb}) : (W+1)'({1'b0, opb});

   always_comb begin
      busy_in     = busy_ff;
      div_in      = div_ff;
      neg_in      = neg_ff;
      zero_div_in = zero_div_ff;
      cnt_in      = cnt_ff;
      acc_in      = acc_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      mb_in       = mb_ff;
      done_in     = 1'b0;
      res_in      = res_ff;
      sa_in       = sa_ff;
      za_in       = za_ff;
      rem_sh      = '0;
      rem_sub     = '0;
      rnd_q       = '0;
      fin_mag     = '0;
      if (ctrl.start && !busy_ff) begin
         // Latch operand magnitudes and the result sign.
         busy_in     = 1'b1;
         div_in      = (ctrl.op == OP_DIV);
         neg_in      = opa[W-1] ^ opb[W-1];
         zero_div_in = (mag_b == '0);
         sa_in       = opa[W-1];
         za_in       = (mag_a == '0);
         acc_in      = '0;
         rem_in      = '0;
         mb_in       = PW'(mag_b);
         if (ctrl.op == OP_DIV) begin
            num_in = PW'(mag_a) << FRACTION_BITS;
            cnt_in = CW'(W + FRACTION_BITS + 1);
         end else begin
            num_in = PW'(mag_a);
            cnt_in = CW'(W + 1);
         end
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            if (div_ff) begin
               // One restoring division step, dividend bits from the top.
               rem_sh  = {rem_ff[PW-2:0], num_ff[W+FRACTION_BITS]};
               rem_sub = {1'b0, rem_sh} - {1'b0, mb_ff};
               num_in  = num_ff << 1;
               if (!rem_sub[PW]) begin
                  rem_in = rem_sub[PW-1:0];
                  acc_in = {acc_ff[PW-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  acc_in = {acc_ff[PW-2:0], 1'b0};
               end
            end else begin
               // One shift-add multiply step, multiplier bits from the top.
               acc_in = (acc_ff << 1) + (num_ff[W] ? mb_ff : '0);
               num_in = num_ff << 1;
            end
            cnt_in = cnt_ff - 1'b1;
         end else begin
            // Round, then saturate into the value range.
            if (div_ff) begin
               rnd_q = (rem_ff >= mb_ff - rem_ff) ? acc_ff + 1'b1 : acc_ff;
            end else begin
               rnd_q = (acc_ff >> FRACTION_BITS) +
                       PW'(acc_ff[FRACTION_BITS-1]);
            end
            fin_mag = rnd_q;
            if (div_ff && zero_div_ff) begin
               if (za_ff) res_in = '0;
               else res_in = sa_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else if (neg_ff) begin
               if (fin_mag >= VMIN_MAG) res_in = {1'b1, {(W-1){1'b0}}};
               else res_in = W'(-fin_mag);
            end else begin
               if (fin_mag >= VMAX_MAG) res_in = {1'b0, {(W-1){1'b1}}};
               else res_in = W'(fin_mag);
            end
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff      <= div_in;
      neg_ff      <= neg_in;
      zero_div_ff <= zero_div_in;
      cnt_ff      <= cnt_in;
      acc_ff      <= acc_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      mb_ff       <= mb_in;
      res_ff      <= res_in;
      sa_ff       <= sa_in;
      za_ff       <= za_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== hw/rtl/pid_controller_step_core.sv =====
// Top level of the PID control step core: registers, state, sequencer.
// Depends on pidc_pkg and pidc_alu.
//
//  channel | direction | ports
//  req     | in        | req_valid, req_ready, req_payload
//  rsp     | out       | rsp_valid, rsp_ready, rsp_payload
//  csr     | in        | csr_write, csr_index, csr_data
//
// An enabled beat takes up to eleven serial operations of the shared unit
// (eight multiplies and three divides, on Q16.16 values by default); a disabled
// beat skips the shared unit. The serial unit sets the length of a beat. Reset
// is synchronous; it clears the controller state and loads the defaults into
// the configuration registers. The request side is ready whenever the
// sequencer is idle; a finished beat waits while an earlier result is still
// held, and a stalled response holds its payload.
module pid_controller_step_core
   import pidc_pkg::*;
#(
   parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF,
   parameter int COUNT_WRAP    = COUNT_WRAP_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int W = VALUE_WIDTH;
   localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] ONE  = W'(1) << FRACTION_BITS;
   localparam longint TI_MIN_L = ((64'd1 << FRACTION_BITS) + 64'd999) / 64'd1000;
   localparam logic signed [W-1:0] TI_MIN = W'(TI_MIN_L);

   // Saturating add and subtract.
   function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
      logic signed [W:0] s;
      s = {a[W-1], a} + {b[W-1], b};
      if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
      return s[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
      logic signed [W:0] s;
      s = {a[W-1], a} - {b[W-1], b};
      if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
      return s[W-1:0];
   endfunction

   // Saturate a 32-bit signed field into the value range.
   function automatic logic signed [W-1:0] sfield(input logic [31:0] x);
      logic signed [63:0] v;
      v = 64'(signed'(x));
      if (v > 64'(VMAX)) return VMAX;
      if (v < 64'(VMIN)) return VMIN;
      return W'(v);
   endfunction

   function automatic logic signed [W-1:0] ufield(input logic [30:0] x);
      logic signed [63:0] v;
      v = 64'(x);
      if (v > 64'(VMAX)) return VMAX;
      return W'(v);
   endfunction

   // Configuration registers.
   logic [31:0] kp_ff, ti_ff, hl_ff, ll_ff;
   logic [30:0] td_ff, lag_ff, dt_ff;
   logic [3:0]  mode_ff;
   logic        ti_fix;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff   <= 32'd65536;
         ti_ff   <= 32'd6553600;
         td_ff   <= 31'd0;
         lag_ff  <= 31'd6554;
         hl_ff   <= 32'd6553600;
         ll_ff   <= 32'd0;
         dt_ff   <= 31'd65536;
         mode_ff <= 4'd3;
      end else if (csr_write) begin
         unique case (reg_index_type'(csr_index))
            REG_KP:   kp_ff   <= csr_data;
            REG_TI:   ti_ff   <= csr_data;
            REG_TD:   td_ff   <= csr_data[30:0];
            REG_LAG:  lag_ff  <= csr_data[30:0];
            REG_HL:   hl_ff   <= csr_data;
            REG_LL:   ll_ff   <= csr_data;
            REG_DT:   dt_ff   <= csr_data[30:0];
            REG_MODE: mode_ff <= csr_data[3:0];
            default:  ;
         endcase
      end else if (ti_fix) begin
         ti_ff <= 32'(TI_MIN);
      end
   end

   // Persistent controller state.
   logic signed [W-1:0] psp_ff, perr_ff, ppv_ff, pout_ff, pint_ff, pfilt_ff, hman_ff;
   logic signed [W-1:0] psp_in, perr_in, ppv_in, pout_in, pint_in, pfilt_in, hman_in;
   logic                hint_ff, hint_in;
   logic [COUNT_BITS-1:0] tick_ff, tick_in;

   // Per-beat working registers.
   seq_state_type       state_ff, state_in;
   req_payload_type     req_ff, req_in;
   logic signed [W-1:0] sp_ff, sp_in, pv_ff, pv_in, e_ff, e_in, kpf_ff, kpf_in;
   logic signed [W-1:0] p_ff, p_in, d_ff, d_in, i_ff, i_in, t_ff, t_in, dt_ff2, dt_in2;
   logic signed [W-1:0] alpha_ff, alpha_in;
   logic                ok_ff, ok_in, ena_ff, ena_in;
   rsp_payload_type     rsp_ff, rsp_in;
   logic                rv_ff, rv_in;

   alu_ctrl_type        actl;
   logic signed [W-1:0] aa, ab, ares;
   logic                adone;

   pidc_alu #(
      .VALUE_WIDTH  (VALUE_WIDTH),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_alu (
      .clock (clock),
      .reset (reset),
      .ctrl  (actl),
      .opa   (aa),
      .opb   (ab),
      .done  (adone),
      .result(ares)
   );

   logic signed [W-1:0] hl_v, ll_v, pred, dsrc, mv, trk, filt;
   logic [W:0]          ti_mag;

   assign hl_v = sfield(hl_ff);
   assign ll_v = sfield(ll_ff);

   // Sequencer: each arithmetic step issues one operation and waits for it.
   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      psp_in = psp_ff; perr_in = perr_ff; ppv_in = ppv_ff; pout_in = pout_ff;
      pint_in = pint_ff; pfilt_in = pfilt_ff; hman_in = hman_ff; hint_in = hint_ff;
      tick_in = tick_ff;
      sp_in = sp_ff; pv_in = pv_ff; e_in = e_ff; kpf_in = kpf_ff; p_in = p_ff;
      d_in = d_ff; i_in = i_ff; t_in = t_ff; dt_in2 = dt_ff2; alpha_in = alpha_ff;
      ok_in = ok_ff; ena_in = ena_ff;
      rsp_in = rsp_ff;
      rv_in  = rv_ff;
      actl.start = 1'b0;
      actl.op    = OP_MUL;
      aa = '0;
      ab = '0;
      ti_fix = 1'b0;
      pred = '0; dsrc = '0; mv = '0; trk = '0; filt = '0;
      ti_mag = '0;
      req_ready = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_payload;
               tick_in = (32'(tick_ff) + 1 >= COUNT_WRAP) ? '0 : tick_ff + 1'b1;
               ena_in = req_payload.enable;
               ok_in  = req_payload.enable;
               sp_in  = req_payload.external_sp_on ? sfield(req_payload.external_setpoint)
                                                   : sfield(req_payload.internal_setpoint);
               pv_in  = sfield(req_payload.process_value);
               dt_in2 = (dt_ff == '0) ? W'(1) : ufield(dt_ff);
               state_in = req_payload.enable ? ST_P : ST_OUT;
            end
         end
         ST_P: begin
            // Proportional term.
            e_in   = ssub(sp_ff, pv_ff);
            kpf_in = mode_ff[0] ? sfield(kp_ff) : ssub('0, sfield(kp_ff));
            actl.start = !adone;
            actl.op = OP_MUL;
            aa = mode_ff[0] ? sfield(kp_ff) : ssub('0, sfield(kp_ff));
            ab = ssub(sp_ff, pv_ff);
            if (adone) begin
               p_in = ares;
               if (mode_ff[3:2] == 2'd3) begin
                  d_in = '0; ok_in = 1'b0; state_in = ST_I1;
               end else state_in = ST_D1;
            end
         end
         ST_D1: begin
            actl.start = !adone; aa = kpf_ff; ab = ufield(td_ff);
            if (adone) begin t_in = ares; state_in = ST_D2; end
         end
         ST_D2: begin
            case (mode_ff[3:2])
               2'd0:    dsrc = ssub(e_ff, perr_ff);
               2'd1:    dsrc = ssub(ppv_ff, pv_ff);
               default: dsrc = ssub(sp_ff, psp_ff);
            endcase
            actl.start = !adone; aa = t_ff; ab = dsrc;
            if (adone) begin t_in = ares; state_in = ST_D3; end
         end
         ST_D3: begin
            actl.start = !adone; actl.op = OP_DIV; aa = t_ff; ab = dt_ff2;
            if (adone) begin d_in = ares; state_in = ST_I1; end
         end
         ST_I1: begin
            // Integral: tracking, hold or accumulate.
            ti_mag = ti_ff[31] ? (W+1)'(-{ti_ff[31], sfield(ti_ff)})
                               : (W+1)'({1'b0, sfield(ti_ff)});
            if (req_ff.manual_on) begin
               i_in = ssub(ssub(pout_ff, p_ff), d_ff);
               state_in = ST_A1;
            end else if (!mode_ff[1]) begin
               i_in = pint_ff;
               state_in = ST_A1;
            end else begin
               if (64'(ti_mag) * 64'd1000 < (64'd1 << FRACTION_BITS)) begin
                  ti_fix = 1'b1;
                  ok_in = 1'b0;
               end
               state_in = ST_I2;
            end
         end
         ST_I2: begin
            actl.start = !adone; actl.op = OP_DIV; aa = kpf_ff; ab = sfield(ti_ff);
            if (adone) begin t_in = ares; state_in = ST_I3; end
         end
         ST_I3: begin
            actl.start = !adone; aa = t_ff; ab = dt_ff2;
            if (adone) begin t_in = ares; state_in = ST_I4; end
         end
         ST_I4: begin
            actl.start = !adone; aa = t_ff; ab = e_ff;
            if (adone) begin
               i_in = sadd(pint_ff, ares);
               pred = sadd(sadd(p_ff, i_in), d_ff);
               if ((pred > hl_v && i_in > pint_ff) || (pred < ll_v && i_in < pint_ff))
                  i_in = pint_ff;
               state_in = ST_A1;
            end
         end
         ST_A1: begin
            // Lag coefficient alpha = dt / (dt + lag * td).
            actl.start = !adone; aa = ufield(lag_ff); ab = ufield(td_ff);
            if (adone) begin t_in = sadd(dt_ff2, ares); state_in = ST_A2; end
         end
         ST_A2: begin
            actl.start = !adone; actl.op = OP_DIV; aa = dt_ff2; ab = t_ff;
            if (adone) begin alpha_in = ares; state_in = ST_F1; end
         end
         ST_F1: begin
            actl.start = !adone; aa = ssub(ONE, alpha_ff); ab = pfilt_ff;
            if (adone) begin t_in = ares; state_in = ST_F2; end
         end
         ST_F2: begin
            actl.start = !adone; aa = alpha_ff; ab = sadd(sadd(p_ff, d_ff), i_ff);
            if (adone) begin t_in = sadd(t_ff, ares); state_in = ST_FIN; end
         end
         ST_FIN: begin
            // Commit state.
            filt = t_ff;
            trk  = req_ff.manual_on ? sfield(req_ff.manual_value) : filt;
            if (trk < ll_v) mv = ll_v;
            else if (trk > hl_v) mv = hl_v;
            else mv = trk;
            psp_in = sp_ff; perr_in = e_ff; ppv_in = pv_ff; pout_in = mv;
            pint_in = i_ff; pfilt_in = filt; hman_in = trk;
            hint_in = !req_ff.external_sp_on;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rv_ff) begin
               rsp_in.drive_value          = 32'(pout_ff);
               rsp_in.setpoint_used        = 32'(psp_ff);
               rsp_in.control_error        = 32'(perr_ff);
               rsp_in.internal_sp_active   = hint_ff;
               rsp_in.status_ok            = ok_ff && ena_ff;
               rsp_in.tracked_manual_value = 32'(hman_ff);
               rsp_in.cycle_count          = tick_ff;
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         psp_ff <= '0; perr_ff <= '0; ppv_ff <= '0; pout_ff <= '0;
         pint_ff <= '0; pfilt_ff <= '0; hman_ff <= '0; hint_ff <= 1'b0;
         tick_ff <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         psp_ff <= psp_in; perr_ff <= perr_in; ppv_ff <= ppv_in; pout_ff <= pout_in;
         pint_ff <= pint_in; pfilt_ff <= pfilt_in; hman_ff <= hman_in; hint_ff <= hint_in;
         tick_ff <= tick_in;
      end
      req_ff <= req_in;
      sp_ff <= sp_in; pv_ff <= pv_in; e_ff <= e_in; kpf_ff <= kpf_in; p_ff <= p_in;
      d_ff <= d_in; i_ff <= i_in; t_ff <= t_in; dt_ff2 <= dt_in2; alpha_ff <= alpha_in;
      ok_ff <= ok_in; ena_ff <= ena_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rv_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the PID control step core with its own step predictor.
// Depends on pidc_pkg and pid_controller_step_core.
module testbench;
   import pidc_pkg::*;

   localparam longint VMAX = 64'sd2147483647;
   localparam longint VMIN = -64'sd2147483648;
   localparam longint ONE_Q = 64'sd65536;
   localparam longint TI_FLOOR = 66;
   localparam int CYCLE_LIMIT = 6000000;
   localparam int PHASES = 15;
   localparam int ITEMS_PER_PHASE = 128;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   pid_controller_step_core dut (.*);

   // Predictor copy of the registers and of the controller state.
   logic [31:0] cfg_reg [8];
   longint last_sp, last_err, last_pv, last_out, last_int, last_filt, last_trk;
   bit last_internal;
   int tick;

   req_payload_type pending_items[$];
   rsp_payload_type expected_results[$];
   bit beat_taken = 0;
   bit idle_on = 1;
   int gap_left = 0;
   int stall_left = 0;
   int cycles = 0;
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;

   initial forever #2 clock = ~clock;

   // Saturating Q16.16 arithmetic.
   function automatic longint sat(longint x);
      return x > VMAX ? VMAX : (x < VMIN ? VMIN : x);
   endfunction

   function automatic longint from_mag(bit neg, longint unsigned m);
      if (neg) begin
         if (m > 64'd2147483648) return VMIN;
         return -longint'(m);
      end
      return m > 64'd2147483647 ? VMAX : longint'(m);
   endfunction

   function automatic longint unsigned mag(longint x);
      return x < 0 ? longint'(-x) : x;
   endfunction

   function automatic longint qmul(longint a, longint b);
      longint unsigned p;
      p = mag(a) * mag(b);
      return from_mag((a < 0) != (b < 0), (p >> 16) + ((p >> 15) & 1));
   endfunction

   function automatic longint qdiv(longint a, longint b);
      longint unsigned n, q, r, mb;
      if (b == 0) return a == 0 ? 0 : (a < 0 ? VMIN : VMAX);
      mb = mag(b);
      n = mag(a) << 16;
      q = n / mb;
      r = n % mb;
      if (r >= mb - r) q++;
      return from_mag((a < 0) != (b < 0), q);
   endfunction

   function automatic longint qadd(longint a, longint b);
      return sat(a + b);
   endfunction

   function automatic longint qsub(longint a, longint b);
      return sat(a - b);
   endfunction

   function automatic longint sval(logic [31:0] v);
      return longint'($signed(v));
   endfunction

   // One control cycle: updates the predictor state and returns the expected beat.
   function automatic rsp_payload_type pid_step(req_payload_type it);
      longint kp, ti, td, lag, hl, ll, dt, sp, pv, e, kpf, p, d, i, sum, alpha, filt, mv, trk;
      longint pred;
      logic [3:0] mode;
      bit ok;
      rsp_payload_type res;
      ok = 0;
      tick = (tick + 1) % 10000;
      if (it.enable) begin
         kp = sval(cfg_reg[REG_KP]);
         ti = sval(cfg_reg[REG_TI]);
         td = cfg_reg[REG_TD];
         lag = cfg_reg[REG_LAG];
         hl = sval(cfg_reg[REG_HL]);
         ll = sval(cfg_reg[REG_LL]);
         dt = cfg_reg[REG_DT];
         mode = cfg_reg[REG_MODE][3:0];
         ok = 1;
         if (dt <= 0) dt = 1;
         sp = it.external_sp_on ? sval(it.external_setpoint) : sval(it.internal_setpoint);
         pv = sval(it.process_value);
         e = qsub(sp, pv);
         kpf = mode[0] ? kp : qsub(0, kp);
         p = qmul(kpf, e);
         // Derivative source select; the fourth code is invalid.
         case (mode[3:2])
            2'd0: d = qdiv(qmul(qmul(kpf, td), qsub(e, last_err)), dt);
            2'd1: d = qdiv(qmul(qmul(kpf, td), qsub(last_pv, pv)), dt);
            2'd2: d = qdiv(qmul(qmul(kpf, td), qsub(sp, last_sp)), dt);
            default: begin
               d = 0;
               ok = 0;
            end
         endcase
         // Integral: bumpless tracking in manual, anti-windup hold in automatic.
         if (it.manual_on) begin
            i = qsub(qsub(last_out, p), d);
         end else if (mode[1]) begin
            if (mag(ti) * 1000 < 65536) begin
               ti = TI_FLOOR;
               cfg_reg[REG_TI] = 32'(TI_FLOOR);
               ok = 0;
            end
            i = qadd(last_int, qmul(qmul(qdiv(kpf, ti), dt), e));
            pred = qadd(qadd(p, i), d);
            if ((pred > hl && i > last_int) || (pred < ll && i < last_int)) i = last_int;
         end else begin
            i = last_int;
         end
         // First-order lag, then the output clamp.
         sum = qadd(qadd(p, d), i);
         alpha = qdiv(dt, qadd(dt, qmul(lag, td)));
         filt = qadd(qmul(qsub(ONE_Q, alpha), last_filt), qmul(alpha, sum));
         trk = it.manual_on ? sval(it.manual_value) : filt;
         mv = trk;
         if (mv < ll) mv = ll;
         else if (mv > hl) mv = hl;
         last_sp = sp;
         last_err = e;
         last_pv = pv;
         last_out = mv;
         last_int = i;
         last_filt = filt;
         last_trk = trk;
         last_internal = !it.external_sp_on;
      end
      res.drive_value = last_out[31:0];
      res.setpoint_used = last_sp[31:0];
      res.control_error = last_err[31:0];
      res.internal_sp_active = last_internal;
      res.status_ok = ok;
      res.tracked_manual_value = last_trk[31:0];
      res.cycle_count = tick[COUNT_BITS-1:0];
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(20, 80);
   endfunction

   // Values biased toward a working range, with extremes and raw bit patterns.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0;
               default: return 32'hffff_ffff;
            endcase
         1, 2: return $urandom;
         default: return 32'($urandom_range(0, 200 * 65536)) - 32'(100 * 65536);
      endcase
   endfunction

   function automatic req_payload_type make_item();
      req_payload_type it;
      it.enable = $urandom_range(0, 9) != 0;
      it.external_sp_on = $urandom_range(0, 1);
      it.external_setpoint = pick_value();
      it.internal_setpoint = pick_value();
      it.process_value = $urandom_range(0, 1) ?
         (it.external_sp_on ? it.external_setpoint : it.internal_setpoint)
         + 32'($urandom_range(0, 8 * 65536)) - 32'(4 * 65536) : pick_value();
      it.manual_on = $urandom_range(0, 6) == 0;
      it.manual_value = pick_value();
      return it;
   endfunction

   // One write beat, then csr_write is dropped before the next write.
   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      logic [31:0] masked;
      masked = value;
      if (idx == REG_TD || idx == REG_LAG || idx == REG_DT) masked[31] = 1'b0;
      if (idx == REG_MODE) masked[31:4] = '0;
      cfg_reg[idx] = masked;
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || expected_results.size() != 0 || req_valid)
         @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic push_item(req_payload_type it);
      pending_items.push_back(it);
      items_sent++;
   endtask

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   // Request driver: new beats and gaps at the falling edge.
   always @(negedge clock) begin
      if (!reset && (!req_valid || beat_taken)) begin
         beat_taken = 0;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_payload <= pending_items.pop_front();
            req_valid <= 1'b1;
            gap_left = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure.
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            stall_left = pick_gap();
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: predict on each accepted request, check each accepted result.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("FAIL pid_controller_step_core");
         $finish;
      end
      if (!reset && req_valid && req_ready) begin
         expected_results.push_back(pid_step(req_payload));
         beat_taken = 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $error("Result beat with no expectation pending");
            errors++;
         end else begin
            rsp_payload_type exp_r;
            exp_r = expected_results.pop_front();
            check_field("drive_value", sval(exp_r.drive_value), sval(rsp_payload.drive_value));
            check_field("setpoint_used", sval(exp_r.setpoint_used),
                        sval(rsp_payload.setpoint_used));
            check_field("control_error", sval(exp_r.control_error),
                        sval(rsp_payload.control_error));
            check_field("internal_sp_active", exp_r.internal_sp_active,
                        rsp_payload.internal_sp_active);
            check_field("status_ok", exp_r.status_ok, rsp_payload.status_ok);
            check_field("tracked_manual_value", sval(exp_r.tracked_manual_value),
                        sval(rsp_payload.tracked_manual_value));
            check_field("cycle_count", exp_r.cycle_count, rsp_payload.cycle_count);
         end
      end
   end

   initial begin
      req_payload_type it;
      cfg_reg = '{32'd65536, 32'd6553600, 32'd0, 32'd6554, 32'd6553600, 32'd0, 32'd65536, 32'd3};
      last_sp = 0; last_err = 0; last_pv = 0; last_out = 0;
      last_int = 0; last_filt = 0; last_trk = 0; last_internal = 0; tick = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed beats under the reset settings: disabled first, then extremes.
      it = '0;
      push_item(it);
      it = '{1'b1, 1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h0};
      push_item(it);
      it = '{1'b1, 1'b1, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 1'b0, 32'h0};
      push_item(it);
      it = '{1'b1, 1'b0, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h0};
      push_item(it);
      it = '{1'b0, 1'b1, 32'h1234_5678, 32'h0, 32'h0, 1'b1, 32'hdead_beef};
      push_item(it);
      it = '{1'b1, 1'b1, 32'h0032_0000, 32'h0, 32'h0028_0000, 1'b1, 32'h8000_0000};
      push_item(it);
      it = '{1'b1, 1'b1, 32'h0032_0000, 32'h0, 32'h0028_0000, 1'b1, 32'h7fff_ffff};
      push_item(it);
      it = '{1'b1, 1'b0, 32'h0, 32'h0032_0000, 32'h0030_0000, 1'b0, 32'h0};
      push_item(it);
      wait_idle();
      // Every derivative source including the invalid one, a tiny integral time
      // that gets clamped, zero cycle time, and crossed limits.
      write_reg(REG_TD, 32'h0001_0000);
      write_reg(REG_TI, 32'd10);
      write_reg(REG_DT, 32'd0);
      for (int m = 0; m < 16; m++) begin
         write_reg(REG_MODE, 32'(m));
         if (m == 8) begin
            write_reg(REG_HL, 32'h0000_0000);
            write_reg(REG_LL, 32'h0064_0000);
         end
         it = '{1'b1, m[0], 32'(m * 65536), 32'h0010_0000, 32'(m * 30000), m[1], 32'h0};
         push_item(it);
         wait_idle();
      end

      // Phases: extremes high, crossed extremes low, then random settings.
      for (int ph = 0; ph < PHASES; ph++) begin
         idle_on = (ph % 4) != 3;
         if (ph == 0) begin
            write_reg(REG_KP, 32'h7fff_ffff);
            write_reg(REG_TI, 32'h7fff_ffff);
            write_reg(REG_TD, 32'h7fff_ffff);
            write_reg(REG_LAG, 32'h7fff_ffff);
            write_reg(REG_HL, 32'h7fff_ffff);
            write_reg(REG_LL, 32'h8000_0000);
            write_reg(REG_DT, 32'h7fff_ffff);
            write_reg(REG_MODE, 32'd15);
         end else if (ph == 1) begin
            write_reg(REG_KP, 32'h8000_0000);
            write_reg(REG_TI, 32'h8000_0000);
            write_reg(REG_TD, 32'h0);
            write_reg(REG_LAG, 32'h0);
            write_reg(REG_HL, 32'h8000_0000);
            write_reg(REG_LL, 32'h7fff_ffff);
            write_reg(REG_DT, 32'h0);
            write_reg(REG_MODE, 32'd0);
         end else begin
            write_reg(REG_KP, $urandom_range(0, 7) == 0 ? $urandom :
                      32'($urandom_range(0, 8 * 65536)) - 32'(4 * 65536));
            write_reg(REG_TI, $urandom_range(0, 5) == 0 ? $urandom_range(0, 120) :
                      ($urandom_range(0, 7) == 0 ? $urandom :
                       32'($urandom_range(32768, 50 * 65536))));
            write_reg(REG_TD, $urandom_range(0, 7) == 0 ? $urandom :
                      32'($urandom_range(0, 5 * 65536)));
            write_reg(REG_LAG, $urandom_range(0, 7) == 0 ? $urandom :
                      32'($urandom_range(0, 65536)));
            write_reg(REG_HL, $urandom_range(0, 7) == 0 ? $urandom :
                      32'($urandom_range(0, 200 * 65536)));
            write_reg(REG_LL, $urandom_range(0, 7) == 0 ? $urandom :
                      32'($urandom_range(0, 100 * 65536)) - 32'(50 * 65536));
            write_reg(REG_DT, $urandom_range(0, 7) == 0 ? $urandom :
                      32'($urandom_range(655, 2 * 65536)));
            write_reg(REG_MODE, $urandom_range(0, 15));
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) push_item(make_item());
         wait_idle();
      end

      repeat (20) @(negedge clock);
      $display("Covered %0d request beats and %0d result beats over %0d setting phases,",
               items_sent, results_seen, PHASES + 17);
      $display("including all derivative sources, manual tracking and output clamping.");
      if (errors == 0 && expected_results.size() == 0) begin
         $display("PASS pid_controller_step_core");
      end else begin
         $display("FAIL pid_controller_step_core");
      end
      $finish;
   end
endmodule
